[hdl/first_free_server_dispatch_core_assert.svh]
// assertion helpers for the dispatch core
`ifndef FIRST_FREE_SERVER_DISPATCH_CORE_ASSERT_SVH
`define FIRST_FREE_SERVER_DISPATCH_CORE_ASSERT_SVH

// checked only while out of reset
`define FFSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FFSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ffsd_pkg.sv]
package ffsd_pkg;

    localparam int SERVERS = 32;
    localparam int IDX_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int CNT_W   = $clog2(SERVERS + 1);
    localparam int MASK_N  = (SERVERS < 32) ? SERVERS : 32;

    localparam logic [19:0] COUNT_MAX        = 20'hFFFFF;
    localparam logic [5:0]  SERVER_COUNT_RST = 6'd32;

    typedef struct packed {
        logic [30:0] arrival_time;
        logic [30:0] duration;
    } req_t;

    typedef struct packed {
        logic        dropped;
        logic [4:0]  server;
        logic [19:0] server_served;
        logic [19:0] max_served;
        logic [31:0] busiest_mask;
    } rsp_t;

    // pick result handed from the dispatch stage to the report stage
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [19:0]      served;
    } pick_t;

    // zero acts as one, anything above the pool size acts as the pool size
    function automatic logic [CNT_W-1:0] clamp_servers(input logic [5:0] v);
        logic [CNT_W-1:0] k;
        if (v == '0)
        begin
            k = CNT_W'(1);
        end
        else if (int'(v) > SERVERS)
        begin
            k = CNT_W'(SERVERS);
        end
        else
        begin
            k = CNT_W'(v);
        end
        return k;
    endfunction

endpackage

[hdl/first_free_server_dispatch_core.sv]
// channel   dir  handshake               word
// --------  ---  ----------------------  -------------------------------------------
// in        in   in_valid / in_stall     req_t: arrival_time, duration
// out       out  out_valid / out_stall   rsp_t: dropped, server, counts, busiest mask
// config    in   server_count_we         server_count_data, 6 bits, no read-back
//
// one word per cycle unless out_stall holds; a word passes s1, s2 and s3 to out
// the pick, the busy-until update and the count update all happen in the dispatch
//   stage in the same cycle against flip-flop state, which sets the one-cycle rate
// rst_n is asynchronous: busy times, counts, max and pointer clear, count goes to 32
// out_stall holds each stage that cannot move on; bubbles ahead still fill, and
//   in_stall rises only once every stage holds a word
`include "first_free_server_dispatch_core_assert.svh"

module first_free_server_dispatch_core
    import ffsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       server_count_we,
    input  logic [5:0] server_count_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  req_t       in_data,

    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_data
);

    // pool state
    logic [CNT_W-1:0] k_reg;                  // active server count, already clamped
    logic [IDX_W-1:0] ptr_reg, ptr_next;      // round robin start point
    logic [31:0]      busy_reg   [SERVERS];
    logic [19:0]      served_reg [SERVERS];
    logic [19:0]      most_reg, most_next;

    // pipeline: input register, dispatch result, output register
    logic  v1_reg, v2_reg, v3_reg;
    req_t  s1_reg;
    pick_t s2_reg;
    rsp_t  s3_reg;

    logic ready1, ready2, ready3;
    logic fire_a, fire_b;

    // dispatch stage signals
    logic [IDX_W-1:0] start_w;
    logic [CNT_W-1:0] start_inc_w;
    logic [SERVERS-1:0] free_w, upper_w, hi_w, cand_w, grant_w;
    logic             found_w;
    logic [IDX_W-1:0] idx_w;
    logic [19:0]      cnt_sel_w, cnt_new_w;
    logic [31:0]      busy_end_w;

    // report stage
    logic [31:0] mask_w;

    // each stage moves when the one after it is empty or moving
    assign ready3   = !v3_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;
    assign fire_a   = v1_reg && ready2;
    assign fire_b   = v2_reg && ready3;

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    // ---------------------------------------------------------------
    // dispatch: free test, rotated first-free pick, state update values
    // ---------------------------------------------------------------
    always_comb
    begin
        // a pointer left beyond a shrunk pool restarts at zero
        start_w = (CNT_W'(ptr_reg) < k_reg) ? ptr_reg : '0;

        for (int s = 0; s < SERVERS; s++)
        begin
            free_w[s]  = (CNT_W'(s) < k_reg) &&
                         (busy_reg[s] <= {1'b0, s1_reg.arrival_time});
            upper_w[s] = (IDX_W'(s) >= start_w);
        end

        // first free at or above start, else wrap to the lowest free one
        hi_w    = free_w & upper_w;
        cand_w  = (|hi_w) ? hi_w : free_w;
        grant_w = cand_w & (~cand_w + SERVERS'(1));
        found_w = |free_w;

        idx_w     = '0;
        cnt_sel_w = '0;
        for (int s = 0; s < SERVERS; s++)
        begin
            if (grant_w[s])
            begin
                idx_w = idx_w | IDX_W'(s);
            end
            cnt_sel_w = cnt_sel_w | (served_reg[s] & {20{grant_w[s]}});
        end

        // saturating served count
        cnt_new_w = (cnt_sel_w < COUNT_MAX) ? (cnt_sel_w + 20'd1) : cnt_sel_w;
        most_next = (found_w && (cnt_new_w > most_reg)) ? cnt_new_w : most_reg;

        busy_end_w = {1'b0, s1_reg.arrival_time} + {1'b0, s1_reg.duration};

        // pointer steps for every request, dropped or not
        start_inc_w = CNT_W'(start_w) + CNT_W'(1);
        ptr_next    = (start_inc_w >= k_reg) ? '0 : IDX_W'(start_inc_w);
    end

    // ---------------------------------------------------------------
    // report: busiest mask over the state as left by this word
    // ---------------------------------------------------------------
    always_comb
    begin
        mask_w = '0;
        for (int s = 0; s < MASK_N; s++)
        begin
            mask_w[s] = (most_reg != '0) && (served_reg[s] == most_reg);
        end
    end

    // control and pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= clamp_servers(SERVER_COUNT_RST);
            ptr_reg  <= '0;
            most_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            for (int s = 0; s < SERVERS; s++)
            begin
                busy_reg[s]   <= '0;
                served_reg[s] <= '0;
            end
        end
        else
        begin
            if (server_count_we)
            begin
                k_reg <= clamp_servers(server_count_data);
            end

            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end

            if (fire_a)
            begin
                ptr_reg  <= ptr_next;
                most_reg <= most_next;
                for (int s = 0; s < SERVERS; s++)
                begin
                    if (grant_w[s])
                    begin
                        busy_reg[s]   <= busy_end_w;
                        served_reg[s] <= cnt_new_w;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
        begin
            s1_reg <= in_data;
        end
        if (fire_a)
        begin
            s2_reg.found  <= found_w;
            s2_reg.idx    <= idx_w;
            s2_reg.served <= cnt_new_w;
        end
        if (fire_b)
        begin
            s3_reg.dropped       <= !s2_reg.found;
            s3_reg.server        <= s2_reg.found ? 5'(s2_reg.idx) : 5'd0;
            s3_reg.server_served <= s2_reg.found ? s2_reg.served : 20'd0;
            s3_reg.max_served    <= most_reg;
            s3_reg.busiest_mask  <= mask_w;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `FFSD_ASSERT(a_k_in_range,
        (k_reg != '0) && (int'(k_reg) <= SERVERS),
        "server count out of range")
    `FFSD_ASSERT(a_most_monotone,
        1'b1 |=> (most_reg >= $past(most_reg)),
        "max served decreased")
    `FFSD_ASSERT(a_served_le_max,
        (v3_reg && !s3_reg.dropped) |-> (s3_reg.server_served <= s3_reg.max_served),
        "served count above max")
    `FFSD_ASSERT(a_busiest_marked,
        (SERVERS <= 32) && v3_reg && !s3_reg.dropped &&
        (s3_reg.server_served == s3_reg.max_served) |-> s3_reg.busiest_mask[s3_reg.server],
        "busiest server missing from mask")

endmodule
